>>> rtl/core/qkd_pkg.sv
// Shared types and constants for the quaternion key decompressor.
// Used by every module under rtl/core; depends on nothing.
package qkd_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned SqrtSteps = 17;

  localparam logic [19:0] UnitSq    = 20'd261121;
  localparam logic [47:0] TimeRound = 48'd16383;
  localparam logic [15:0] TimeDiv   = 16'd32767;
  localparam logic [16:0] MagMax    = 17'd32767;

  localparam int unsigned PaddrW = 3;
  localparam logic RegMinTime = 1'b0;
  localparam logic RegMaxTime = 1'b1;

  typedef struct packed {
    logic [15:0] time_word;
    logic [31:0] packed_rotation;
    logic        last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] key_time;
    logic               interpolate_next;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic               corrupt;
    logic               last_out;
  } out_rsp_t;

  typedef struct packed {
    logic signed [31:0] key_time;
    logic               interp;
    logic [3:0]         neg;
    logic               corrupt;
    logic               last;
  } side_t;

  typedef struct packed {
    logic [19:0] rem;
    logic [32:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NumLanes-1:0] lane;
    logic [19:0]              den;
    side_t                    side;
  } div_bus_t;

  typedef struct packed {
    logic [33:0] rad;
    logic [18:0] rem;
    logic [16:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    sqrt_lane_t [NumLanes-1:0] lane;
    side_t                     side;
  } sqrt_bus_t;

endpackage

>>> rtl/core/qkd_div_cell.sv
// One restoring division step for all four quaternion lanes.
// Depends on qkd_pkg.
module qkd_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  qkd_pkg::div_bus_t bus_i,
  output logic              valid_o,
  input  logic              ready_i,
  output qkd_pkg::div_bus_t bus_o
);
  import qkd_pkg::*;

  logic     valid_q;
  logic     load;
  div_bus_t bus_d, bus_q;

  assign load    = ~valid_q | ready_i;
  assign ready_o = load;
  assign valid_o = valid_q;
  assign bus_o   = bus_q;

  always_comb begin
    logic [20:0] dbl;
    logic        qbit;
    bus_d = bus_i;
    for (int l = 0; l < NumLanes; l++) begin
      dbl  = {bus_i.lane[l].rem, 1'b0};
      qbit = (dbl >= {1'b0, bus_i.den});
      if (qbit) begin
        bus_d.lane[l].rem = 20'(dbl - {1'b0, bus_i.den});
      end else begin
        bus_d.lane[l].rem = dbl[19:0];
      end
      bus_d.lane[l].quo = {bus_i.lane[l].quo[31:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      bus_q <= bus_d;
    end
  end

endmodule

>>> rtl/core/qkd_sqrt_cell.sv
// One digit-by-digit square root step for all four quaternion lanes.
// Depends on qkd_pkg.
module qkd_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  qkd_pkg::sqrt_bus_t bus_i,
  output logic               valid_o,
  input  logic               ready_i,
  output qkd_pkg::sqrt_bus_t bus_o
);
  import qkd_pkg::*;

  logic      valid_q;
  logic      load;
  sqrt_bus_t bus_d, bus_q;

  assign load    = ~valid_q | ready_i;
  assign ready_o = load;
  assign valid_o = valid_q;
  assign bus_o   = bus_q;

  always_comb begin
    logic [20:0] cur;
    logic [20:0] trial;
    bus_d = bus_i;
    for (int l = 0; l < NumLanes; l++) begin
      cur   = {bus_i.lane[l].rem, bus_i.lane[l].rad[33:32]};
      trial = {2'b00, bus_i.lane[l].root, 2'b01};
      if (cur >= trial) begin
        bus_d.lane[l].rem  = 19'(cur - trial);
        bus_d.lane[l].root = {bus_i.lane[l].root[15:0], 1'b1};
      end else begin
        bus_d.lane[l].rem  = cur[18:0];
        bus_d.lane[l].root = {bus_i.lane[l].root[15:0], 1'b0};
      end
      bus_d.lane[l].rad = {bus_i.lane[l].rad[31:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      bus_q <= bus_d;
    end
  end

endmodule

>>> rtl/core/quaternion_key_decompressor.sv
// Top level of the quaternion key decompressor: register port, front stages,
// division and square root cell chains and the output register.
// Depends on qkd_pkg, qkd_div_cell and qkd_sqrt_cell.
//
//  channel | signals                                   | direction
//  in      | in_valid_i, in_ready_o, in_req_i          | request in
//  out     | out_valid_o, out_ready_i, out_rsp_o       | request out
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | register access
//
// One request is taken per cycle while the pipe is not stalled; each result
// passes through five front stages, 32 division cells, 17 square root cells and one output.
// Reset clears all valid flags and both time registers.
// Every stage holds its request while the next is full, so a stalled output
// stops the pipe only once all stages are occupied.
module quaternion_key_decompressor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  qkd_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output qkd_pkg::out_rsp_t               out_rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qkd_pkg::PaddrW-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import qkd_pkg::*;

  // Configuration registers and the derived span.
  logic signed [31:0] min_q, max_q;
  logic               spneg_q;
  logic [32:0]        spmag_q;
  logic               wr;
  logic signed [32:0] span_new;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign prdata = (paddr[2] == RegMaxTime) ? max_q : min_q;

  always_comb begin
    if (paddr[2] == RegMinTime) begin
      span_new = 33'(signed'(max_q)) - 33'(signed'(pwdata));
    end else begin
      span_new = 33'(signed'(pwdata)) - 33'(signed'(min_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= '0;
      spneg_q <= 1'b0;
      spmag_q <= '0;
    end else if (wr) begin
      if (paddr[2] == RegMinTime) begin
        min_q <= pwdata;
      end else begin
        max_q <= pwdata;
      end
      spneg_q <= span_new[32];
      spmag_q <= span_new[32] ? 33'(-span_new) : 33'(span_new);
    end
  end

  // Front stages.
  logic [4:0] f_valid_q;
  logic [4:0] f_ld;
  logic       div_ready [DivSteps+1];
  logic       div_valid [DivSteps+1];
  div_bus_t   div_bus   [DivSteps+1];

  assign f_ld[4] = ~f_valid_q[4] | div_ready[0];
  assign f_ld[3] = ~f_valid_q[3] | f_ld[4];
  assign f_ld[2] = ~f_valid_q[2] | f_ld[3];
  assign f_ld[1] = ~f_valid_q[1] | f_ld[2];
  assign f_ld[0] = ~f_valid_q[0] | f_ld[1];
  assign in_ready_o = f_ld[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= '0;
    end else begin
      if (f_ld[0]) begin
        f_valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < 5; k++) begin
        if (f_ld[k]) begin
          f_valid_q[k] <= f_valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: product and squares.
  logic [47:0] s1_prod;
  logic [17:0] s1_sq [3];
  side_t       s1_side;

  always_ff @(posedge clk_i) begin
    if (f_ld[0] && in_valid_i) begin
      s1_prod  <= 48'({33'd0, in_req_i.time_word[14:0]} * {15'd0, spmag_q});
      s1_sq[0] <= {9'd0, in_req_i.packed_rotation[8:0]} *
                  {9'd0, in_req_i.packed_rotation[8:0]};
      s1_sq[1] <= {9'd0, in_req_i.packed_rotation[18:10]} *
                  {9'd0, in_req_i.packed_rotation[18:10]};
      s1_sq[2] <= {9'd0, in_req_i.packed_rotation[28:20]} *
                  {9'd0, in_req_i.packed_rotation[28:20]};
      s1_side.key_time <= '0;
      s1_side.interp   <= in_req_i.time_word[15];
      s1_side.neg      <= {in_req_i.packed_rotation[31], in_req_i.packed_rotation[29],
                           in_req_i.packed_rotation[19], in_req_i.packed_rotation[9]};
      s1_side.corrupt  <= in_req_i.packed_rotation[30];
      s1_side.last     <= in_req_i.last_in;
    end
  end

  // Stage 2: rounding offset, sum of squares, denominator and w squared.
  logic [47:0] s2_n;
  logic [19:0] s2_sq [NumLanes];
  logic [19:0] s2_den;
  side_t       s2_side;
  logic [19:0] sum_sq;

  assign sum_sq = 20'(s1_sq[0]) + 20'(s1_sq[1]) + 20'(s1_sq[2]);

  always_ff @(posedge clk_i) begin
    if (f_ld[1] && f_valid_q[0]) begin
      s2_n     <= s1_prod + TimeRound;
      s2_sq[0] <= 20'(s1_sq[0]);
      s2_sq[1] <= 20'(s1_sq[1]);
      s2_sq[2] <= 20'(s1_sq[2]);
      s2_sq[3] <= (sum_sq < UnitSq) ? (UnitSq - sum_sq) : '0;
      s2_den   <= (sum_sq > UnitSq) ? sum_sq : UnitSq;
      s2_side  <= s1_side;
    end
  end

  // Stage 3: reciprocal series for the divide by 32767, first quotient bit.
  logic [47:0] s3_a, s3_n;
  div_bus_t    s3_bus;
  div_bus_t    s3_bus_d;

  always_comb begin
    s3_bus_d.den  = s2_den;
    s3_bus_d.side = s2_side;
    for (int l = 0; l < NumLanes; l++) begin
      if (s2_sq[l] >= s2_den) begin
        s3_bus_d.lane[l].rem = 20'(s2_sq[l] - s2_den);
        s3_bus_d.lane[l].quo = 33'd1;
      end else begin
        s3_bus_d.lane[l].rem = s2_sq[l];
        s3_bus_d.lane[l].quo = 33'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ld[2] && f_valid_q[1]) begin
      s3_a   <= s2_n + (s2_n >> 15) + (s2_n >> 30) + (s2_n >> 45);
      s3_n   <= s2_n;
      s3_bus <= s3_bus_d;
    end
  end

  // Stage 4: trial quotient and remainder.
  logic [32:0] s4_q0;
  logic [15:0] s4_r;
  div_bus_t    s4_bus;
  logic [47:0] rem_full;

  assign rem_full = s3_n - {s3_a[47:15], 15'd0} + {15'd0, s3_a[47:15]};

  always_ff @(posedge clk_i) begin
    if (f_ld[3] && f_valid_q[2]) begin
      s4_q0  <= s3_a[47:15];
      s4_r   <= rem_full[15:0];
      s4_bus <= s3_bus;
    end
  end

  // Stage 5: correction, offset and saturation of the key time.
  div_bus_t           s5_bus;
  div_bus_t           s5_bus_d;
  logic [33:0]        scaled;
  logic signed [34:0] tm;
  logic signed [31:0] tm_sat;

  always_comb begin
    scaled = {1'b0, s4_q0} + {33'd0, (s4_r >= TimeDiv)};
    if (spneg_q) begin
      tm = 35'(signed'(min_q)) - signed'({1'b0, scaled});
    end else begin
      tm = 35'(signed'(min_q)) + signed'({1'b0, scaled});
    end
    if (tm > 35'sh07FFFFFFF) begin
      tm_sat = 32'sh7FFFFFFF;
    end else if (tm < -35'sh080000000) begin
      tm_sat = 32'sh80000000;
    end else begin
      tm_sat = tm[31:0];
    end
    s5_bus_d               = s4_bus;
    s5_bus_d.side.key_time = tm_sat;
  end

  always_ff @(posedge clk_i) begin
    if (f_ld[4] && f_valid_q[3]) begin
      s5_bus <= s5_bus_d;
    end
  end

  // Division cell chain.
  assign div_valid[0] = f_valid_q[4];
  assign div_bus[0]   = s5_bus;

  logic      sq_ready [SqrtSteps+1];
  logic      sq_valid [SqrtSteps+1];
  sqrt_bus_t sq_bus   [SqrtSteps+1];

  assign div_ready[DivSteps] = sq_ready[0];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    qkd_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .ready_o (div_ready[k]),
      .bus_i   (div_bus[k]),
      .valid_o (div_valid[k+1]),
      .ready_i (div_ready[k+1]),
      .bus_o   (div_bus[k+1])
    );
  end

  // Square root cell chain.
  sqrt_bus_t sq_head;

  always_comb begin
    sq_head.side = div_bus[DivSteps].side;
    for (int l = 0; l < NumLanes; l++) begin
      sq_head.lane[l].rad  = {1'b0, div_bus[DivSteps].lane[l].quo};
      sq_head.lane[l].rem  = '0;
      sq_head.lane[l].root = '0;
    end
  end
  assign sq_bus[0]   = sq_head;
  assign sq_valid[0] = div_valid[DivSteps];

  logic out_ld;
  logic out_valid_q;
  assign sq_ready[SqrtSteps] = out_ld;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    qkd_sqrt_cell u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[k]),
      .ready_o (sq_ready[k]),
      .bus_i   (sq_bus[k]),
      .valid_o (sq_valid[k+1]),
      .ready_i (sq_ready[k+1]),
      .bus_o   (sq_bus[k+1])
    );
  end

  // Output register: rounding, saturation and sign.
  out_rsp_t    out_q;
  logic [15:0] comp [NumLanes];

  always_comb begin
    logic [17:0] rnd;
    logic [16:0] mag;
    for (int l = 0; l < NumLanes; l++) begin
      rnd = {1'b0, sq_bus[SqrtSteps].lane[l].root} + 18'd1;
      mag = (rnd[17:1] > MagMax) ? MagMax : rnd[17:1];
      comp[l] = sq_bus[SqrtSteps].side.neg[l] ? 16'(-mag) : mag[15:0];
    end
  end

  assign out_ld = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= sq_valid[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld && sq_valid[SqrtSteps]) begin
      out_q.key_time         <= sq_bus[SqrtSteps].side.key_time;
      out_q.interpolate_next <= sq_bus[SqrtSteps].side.interp;
      out_q.rot_x            <= comp[0];
      out_q.rot_y            <= comp[1];
      out_q.rot_z            <= comp[2];
      out_q.rot_w            <= comp[3];
      out_q.corrupt          <= sq_bus[SqrtSteps].side.corrupt;
      out_q.last_out         <= sq_bus[SqrtSteps].side.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("Input stalled without output back-pressure.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.rot_x != 16'h8000 && out_rsp_o.rot_y != 16'h8000 &&
                     out_rsp_o.rot_z != 16'h8000 && out_rsp_o.rot_w != 16'h8000))
    else $error("Rotation component below -32767.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && spmag_q == '0) |-> (out_rsp_o.key_time == min_q))
    else $error("Key time differs from start time on an empty range.");

endmodule
